// ----- src/csr_pkg.sv -----
// Package for the celestial sphere rotation pipeline: types, constants, CORDIC angle table.
`timescale 1ns / 1ps

package csr_pkg;

    localparam int CORDIC_STAGES = 28;
    localparam int ISQRT_STAGES  = 31;

    typedef logic signed [31:0] ang_t;
    typedef logic signed [35:0] vec_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [65:0] acc_t;
    typedef logic [61:0]        root_t;

    localparam ang_t  PI_Q28      = 32'sd843314857;
    localparam ang_t  HALF_PI_Q28 = 32'sd421657428;
    localparam trig_t ONE_Q30     = 32'sd1073741824;
    localparam vec_t  GAIN_Q30    = 36'sd652032874;
    localparam root_t ONE_SQ_Q60  = root_t'(1) << 60;

    localparam logic REG_REF_ALPHA = 1'b0;
    localparam logic REG_REF_DELTA = 1'b1;

    function automatic ang_t step_angle(input int i);
        ang_t a;
        case (i)
            0:       a = 32'sd210828714;
            1:       a = 32'sd124459457;
            2:       a = 32'sd65760959;
            3:       a = 32'sd33381290;
            4:       a = 32'sd16755422;
            5:       a = 32'sd8385879;
            6:       a = 32'sd4193963;
            7:       a = 32'sd2097109;
            8:       a = 32'sd1048571;
            9:       a = 32'sd524287;
            10:      a = 32'sd262144;
            default:
            begin
                if (i <= 28)
                begin
                    a = ang_t'(1) << (28 - i);
                end
                else
                begin
                    a = '0;
                end
            end
        endcase
        return a;
    endfunction

endpackage

// ----- src/celestial_sphere_rotation.sv -----
// Top level: pipelined rotation of a sphere point about a configured reference point.
// Throughput: one point per cycle while out_stall does not hold the output stage;
// every CORDIC iteration and square root bit is a stage.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the stage valid bits and sets ref_alpha and ref_delta to zero.
`timescale 1ns / 1ps

module celestial_sphere_rotation
    import csr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [30:0] point_alpha,
    input  logic signed [29:0] point_delta,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [30:0] result_alpha,
    output logic signed [29:0] result_delta
);

    localparam int N     = CORDIC_STAGES;
    localparam int DEPTH = 2 * N + ISQRT_STAGES + 9;

    logic signed [30:0] ref_alpha_reg;
    logic signed [29:0] ref_delta_reg;
    logic [DEPTH-1:0]   vld_reg;
    logic               adv;
    logic               accept;

    assign adv      = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_alpha_reg <= '0;
            ref_delta_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_REF_ALPHA: ref_alpha_reg <= cfg_data;
                REG_REF_DELTA: ref_delta_reg <= cfg_data[29:0];
                default:       ref_alpha_reg <= ref_alpha_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], accept};
        end
    end

    // fold angles into a quarter turn
    vec_t sc_x_reg [0:N][0:3];
    vec_t sc_y_reg [0:N][0:3];
    ang_t sc_z_reg [0:N][0:3];
    logic sc_neg_reg [0:N][0:3];
    logic sc_cmd_reg [0:N];

    ang_t fold_in [0:3];
    ang_t fold_z [0:3];
    logic fold_neg [0:3];

    always_comb
    begin
        fold_in[0] = ang_t'(ref_alpha_reg);
        fold_in[1] = ang_t'(ref_delta_reg);
        fold_in[2] = ang_t'(point_alpha);
        fold_in[3] = ang_t'(point_delta);
        for (int l = 0; l < 4; l++)
        begin
            if (fold_in[l] > HALF_PI_Q28)
            begin
                fold_z[l]   = fold_in[l] - PI_Q28;
                fold_neg[l] = 1'b1;
            end
            else if (fold_in[l] < -HALF_PI_Q28)
            begin
                fold_z[l]   = fold_in[l] + PI_Q28;
                fold_neg[l] = 1'b1;
            end
            else
            begin
                fold_z[l]   = fold_in[l];
                fold_neg[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                sc_x_reg[0][l]   <= GAIN_Q30;
                sc_y_reg[0][l]   <= '0;
                sc_z_reg[0][l]   <= fold_z[l];
                sc_neg_reg[0][l] <= fold_neg[l];
            end
            sc_cmd_reg[0] <= command;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_sc
        vec_t sx [0:3];
        vec_t sy [0:3];
        ang_t sz [0:3];

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (sc_z_reg[k-1][l] >= 0)
                begin
                    sx[l] = sc_x_reg[k-1][l] - (sc_y_reg[k-1][l] >>> (k - 1));
                    sy[l] = sc_y_reg[k-1][l] + (sc_x_reg[k-1][l] >>> (k - 1));
                    sz[l] = sc_z_reg[k-1][l] - step_angle(k - 1);
                end
                else
                begin
                    sx[l] = sc_x_reg[k-1][l] + (sc_y_reg[k-1][l] >>> (k - 1));
                    sy[l] = sc_y_reg[k-1][l] - (sc_x_reg[k-1][l] >>> (k - 1));
                    sz[l] = sc_z_reg[k-1][l] + step_angle(k - 1);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    sc_x_reg[k][l]   <= sx[l];
                    sc_y_reg[k][l]   <= sy[l];
                    sc_z_reg[k][l]   <= sz[l];
                    sc_neg_reg[k][l] <= sc_neg_reg[k-1][l];
                end
                sc_cmd_reg[k] <= sc_cmd_reg[k-1];
            end
        end
    end

    // restore sign of folded sine and cosine
    trig_t m1_cos_reg [0:3];
    trig_t m1_sin_reg [0:3];
    logic  m1_cmd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                m1_cos_reg[l] <= sc_neg_reg[N][l] ? -trig_t'(sc_x_reg[N][l])
                                                  : trig_t'(sc_x_reg[N][l]);
                m1_sin_reg[l] <= sc_neg_reg[N][l] ? -trig_t'(sc_y_reg[N][l])
                                                  : trig_t'(sc_y_reg[N][l]);
            end
            m1_cmd_reg <= sc_cmd_reg[N];
        end
    end

    // unit vector and reference products
    trig_t m2_v_reg [0:2];
    trig_t m2_sdca_reg, m2_sdsa_reg, m2_cdca_reg, m2_cdsa_reg;
    trig_t m2_ca_reg, m2_sa_reg, m2_cd_reg, m2_sd_reg;
    logic  m2_cmd_reg;

    function automatic trig_t mul30(input trig_t a, input trig_t b);
        prod_t p;
        p = prod_t'(a) * prod_t'(b);
        return trig_t'(p >>> 30);
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_v_reg[0]  <= mul30(m1_cos_reg[3], m1_cos_reg[2]);
            m2_v_reg[1]  <= mul30(m1_cos_reg[3], m1_sin_reg[2]);
            m2_v_reg[2]  <= m1_sin_reg[3];
            m2_sdca_reg  <= mul30(m1_sin_reg[1], m1_cos_reg[0]);
            m2_sdsa_reg  <= mul30(m1_sin_reg[1], m1_sin_reg[0]);
            m2_cdca_reg  <= mul30(m1_cos_reg[1], m1_cos_reg[0]);
            m2_cdsa_reg  <= mul30(m1_cos_reg[1], m1_sin_reg[0]);
            m2_ca_reg    <= m1_cos_reg[0];
            m2_sa_reg    <= m1_sin_reg[0];
            m2_cd_reg    <= m1_cos_reg[1];
            m2_sd_reg    <= m1_sin_reg[1];
            m2_cmd_reg   <= m1_cmd_reg;
        end
    end

    // matrix products, transposed for the inverse command
    trig_t mat [0:2][0:2];
    prod_t m3_p_reg [0:2][0:2];

    always_comb
    begin
        mat[0][0] = -m2_sdca_reg;
        mat[0][1] = -m2_sdsa_reg;
        mat[0][2] = m2_cd_reg;
        mat[1][0] = -m2_sa_reg;
        mat[1][1] = m2_ca_reg;
        mat[1][2] = '0;
        mat[2][0] = -m2_cdca_reg;
        mat[2][1] = -m2_cdsa_reg;
        mat[2][2] = -m2_sd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    m3_p_reg[i][j] <= prod_t'(m2_cmd_reg ? mat[j][i] : mat[i][j])
                                      * prod_t'(m2_v_reg[j]);
                end
            end
        end
    end

    // dot products
    vec_t m4_r_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m4_r_reg[i] <= vec_t'((acc_t'(m3_p_reg[i][0]) + acc_t'(m3_p_reg[i][1])
                                       + acc_t'(m3_p_reg[i][2])) >>> 30);
            end
        end
    end

    // saturate z to unit range
    vec_t  m5_r0_reg, m5_r1_reg;
    trig_t m5_vz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m5_r0_reg <= m4_r_reg[0];
            m5_r1_reg <= m4_r_reg[1];
            if (m4_r_reg[2] > vec_t'(ONE_Q30))
            begin
                m5_vz_reg <= ONE_Q30;
            end
            else if (m4_r_reg[2] < -vec_t'(ONE_Q30))
            begin
                m5_vz_reg <= -ONE_Q30;
            end
            else
            begin
                m5_vz_reg <= trig_t'(m4_r_reg[2]);
            end
        end
    end

    // square root radicand, then one root bit per stage
    root_t q_n_reg   [0:ISQRT_STAGES];
    root_t q_res_reg [0:ISQRT_STAGES];
    vec_t  q_r0_reg  [0:ISQRT_STAGES];
    vec_t  q_r1_reg  [0:ISQRT_STAGES];
    trig_t q_vz_reg  [0:ISQRT_STAGES];
    prod_t vz_sq;

    assign vz_sq = prod_t'(m5_vz_reg) * prod_t'(m5_vz_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_n_reg[0]   <= ONE_SQ_Q60 - root_t'(vz_sq);
            q_res_reg[0] <= '0;
            q_r0_reg[0]  <= m5_r0_reg;
            q_r1_reg[0]  <= m5_r1_reg;
            q_vz_reg[0]  <= m5_vz_reg;
        end
    end

    for (genvar j = 1; j <= ISQRT_STAGES; j++)
    begin : g_sq
        localparam root_t BIT = root_t'(1) << (60 - 2 * (j - 1));
        root_t trial;

        assign trial = q_res_reg[j-1] + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (q_n_reg[j-1] >= trial)
                begin
                    q_n_reg[j]   <= q_n_reg[j-1] - trial;
                    q_res_reg[j] <= (q_res_reg[j-1] >> 1) + BIT;
                end
                else
                begin
                    q_n_reg[j]   <= q_n_reg[j-1];
                    q_res_reg[j] <= q_res_reg[j-1] >> 1;
                end
                q_r0_reg[j] <= q_r0_reg[j-1];
                q_r1_reg[j] <= q_r1_reg[j-1];
                q_vz_reg[j] <= q_vz_reg[j-1];
            end
        end
    end

    // atan2 lanes: 0 longitude from (y, x), 1 latitude from (z, root)
    vec_t at_x_reg [0:N][0:1];
    vec_t at_y_reg [0:N][0:1];
    ang_t at_z_reg [0:N][0:1];
    logic at_zero_reg [0:N][0:1];

    vec_t a0_x [0:1];
    vec_t a0_y [0:1];

    always_comb
    begin
        a0_x[0] = q_r0_reg[ISQRT_STAGES];
        a0_y[0] = q_r1_reg[ISQRT_STAGES];
        a0_x[1] = vec_t'(q_res_reg[ISQRT_STAGES]);
        a0_y[1] = vec_t'(q_vz_reg[ISQRT_STAGES]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                at_zero_reg[0][l] <= (a0_x[l] == '0) && (a0_y[l] == '0);
                if (a0_x[l] < 0)
                begin
                    at_x_reg[0][l] <= -a0_x[l];
                    at_y_reg[0][l] <= -a0_y[l];
                    at_z_reg[0][l] <= (a0_y[l] >= 0) ? PI_Q28 : -PI_Q28;
                end
                else
                begin
                    at_x_reg[0][l] <= a0_x[l];
                    at_y_reg[0][l] <= a0_y[l];
                    at_z_reg[0][l] <= '0;
                end
            end
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_at
        vec_t ax [0:1];
        vec_t ay [0:1];
        ang_t az [0:1];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (at_y_reg[k-1][l] > 0)
                begin
                    ax[l] = at_x_reg[k-1][l] + (at_y_reg[k-1][l] >>> (k - 1));
                    ay[l] = at_y_reg[k-1][l] - (at_x_reg[k-1][l] >>> (k - 1));
                    az[l] = at_z_reg[k-1][l] + step_angle(k - 1);
                end
                else
                begin
                    ax[l] = at_x_reg[k-1][l] - (at_y_reg[k-1][l] >>> (k - 1));
                    ay[l] = at_y_reg[k-1][l] + (at_x_reg[k-1][l] >>> (k - 1));
                    az[l] = at_z_reg[k-1][l] - step_angle(k - 1);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    at_x_reg[k][l]    <= ax[l];
                    at_y_reg[k][l]    <= ay[l];
                    at_z_reg[k][l]    <= az[l];
                    at_zero_reg[k][l] <= at_zero_reg[k-1][l];
                end
            end
        end
    end

    // clamp and hold result
    logic signed [30:0] result_alpha_reg;
    logic signed [29:0] result_delta_reg;
    ang_t za, zd;

    assign za = at_zero_reg[N][0] ? '0 : at_z_reg[N][0];
    assign zd = at_zero_reg[N][1] ? '0 : at_z_reg[N][1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (za > PI_Q28)
            begin
                result_alpha_reg <= PI_Q28[30:0];
            end
            else if (za < -PI_Q28)
            begin
                result_alpha_reg <= 31'(-PI_Q28);
            end
            else
            begin
                result_alpha_reg <= za[30:0];
            end
            if (zd > HALF_PI_Q28)
            begin
                result_delta_reg <= HALF_PI_Q28[29:0];
            end
            else if (zd < -HALF_PI_Q28)
            begin
                result_delta_reg <= 30'(-HALF_PI_Q28);
            end
            else
            begin
                result_delta_reg <= zd[29:0];
            end
        end
    end

    assign result_alpha = result_alpha_reg;
    assign result_delta = result_delta_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> vld_reg[0])
        else $error("accepted transfer missing from first stage");

    a_last_advances: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[DEPTH-2] |=> out_valid)
        else $error("item lost before output stage");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ang_t'(result_alpha) <= PI_Q28) && (ang_t'(result_alpha) >= -PI_Q28))
        else $error("result_alpha out of range");

    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ang_t'(result_delta) <= HALF_PI_Q28)
        && (ang_t'(result_delta) >= -HALF_PI_Q28))
        else $error("result_delta out of range");

endmodule
